@@ rtl/core/cce_pkg.sv @@
// Package for the cone circumcenter estimator.
// Holds widths, status codes, the micro-op program and the controller/datapath structs.
package cce_pkg;

    localparam int unsigned MAX_POINTS_DEF = 256;
    localparam int unsigned COORD_W        = 20;
    localparam int unsigned PLANE_W        = 16;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned MUL_W          = 22;
    localparam int unsigned PROD_W         = 2 * MUL_W;
    localparam int unsigned ACC_W          = 66;
    localparam int unsigned DIV_W          = 66;
    localparam int unsigned DIST_W         = 40;
    localparam int unsigned SQ_W           = 40;
    localparam int unsigned HALF_W         = 20;
    localparam int unsigned PT_W           = 3 * COORD_W;
    localparam int unsigned PC_W           = 5;
    localparam int unsigned NUM_OPND       = 27;

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_C = 2'd2;

    localparam logic signed [COORD_W-1:0] CENTER_MAX = 20'sh7FFFF;
    localparam logic signed [COORD_W-1:0] CENTER_MIN = 20'sh80000;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_ZDET  = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        OP_PA, OP_PB, OP_PC, OP_CX, OP_CY, OP_CZ, OP_PX, OP_PY, OP_PZ,
        OP_X1, OP_Y1, OP_X2, OP_Y2, OP_X3, OP_Y3,
        OP_D23, OP_D31, OP_D12, OP_E32, OP_E13, OP_E21,
        OP_S1L, OP_S1H, OP_S2L, OP_S2H, OP_S3L, OP_S3H
    } t_opnd;

    typedef enum logic [2:0] {
        D_NONE, D_REF, D_S1, D_S2, D_S3, D_DET, D_NX, D_NY
    } t_dest;

    typedef struct packed {
        t_opnd a;
        t_opnd b;
        logic  sh;
        logic  clr;
        t_dest dest;
    } t_uop;

    typedef enum logic [2:0] {
        DS_CX, DS_CY, DS_CZ, DS_NX, DS_NY
    } t_dsel;

    localparam logic [PC_W-1:0] PC_REF_START  = 5'd0;
    localparam logic [PC_W-1:0] PC_REF_END    = 5'd2;
    localparam logic [PC_W-1:0] PC_DIST_START = 5'd3;
    localparam logic [PC_W-1:0] PC_DIST_END   = 5'd5;
    localparam logic [PC_W-1:0] PC_CIRC_START = 5'd6;
    localparam logic [PC_W-1:0] PC_CIRC_END   = 5'd26;

    typedef struct packed {
        logic            load;
        logic            clear;
        logic            div_start;
        t_dsel           div_sel;
        logic            div_wr;
        logic            mul;
        logic            acc;
        logic [PC_W-1:0] pc;
        logic            k_clr;
        logic            rd;
        logic            ins;
        logic            set_empty;
        logic            set_zdet;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic k_done;
        logic div_done;
        logic det_zero;
    } t_sts;

    function automatic t_uop mk(input t_opnd a, input t_opnd b, input logic sh,
                                input logic clr, input t_dest dest);
        t_uop u;
        u.a    = a;
        u.b    = b;
        u.sh   = sh;
        u.clr  = clr;
        u.dest = dest;
        return u;
    endfunction

    // Products accumulate into one register; sh weights the product by 2^20.
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            5'd0:    u = mk(OP_PA,  OP_CX,  1'b0, 1'b1, D_NONE);
            5'd1:    u = mk(OP_PB,  OP_CY,  1'b0, 1'b0, D_NONE);
            5'd2:    u = mk(OP_PC,  OP_CZ,  1'b0, 1'b0, D_REF);
            5'd3:    u = mk(OP_PA,  OP_PX,  1'b0, 1'b1, D_NONE);
            5'd4:    u = mk(OP_PB,  OP_PY,  1'b0, 1'b0, D_NONE);
            5'd5:    u = mk(OP_PC,  OP_PZ,  1'b0, 1'b0, D_NONE);
            5'd6:    u = mk(OP_X1,  OP_X1,  1'b0, 1'b1, D_NONE);
            5'd7:    u = mk(OP_Y1,  OP_Y1,  1'b0, 1'b0, D_S1);
            5'd8:    u = mk(OP_X2,  OP_X2,  1'b0, 1'b1, D_NONE);
            5'd9:    u = mk(OP_Y2,  OP_Y2,  1'b0, 1'b0, D_S2);
            5'd10:   u = mk(OP_X3,  OP_X3,  1'b0, 1'b1, D_NONE);
            5'd11:   u = mk(OP_Y3,  OP_Y3,  1'b0, 1'b0, D_S3);
            5'd12:   u = mk(OP_X1,  OP_D23, 1'b0, 1'b1, D_NONE);
            5'd13:   u = mk(OP_X2,  OP_D31, 1'b0, 1'b0, D_NONE);
            5'd14:   u = mk(OP_X3,  OP_D12, 1'b0, 1'b0, D_DET);
            5'd15:   u = mk(OP_S1L, OP_D23, 1'b0, 1'b1, D_NONE);
            5'd16:   u = mk(OP_S1H, OP_D23, 1'b1, 1'b0, D_NONE);
            5'd17:   u = mk(OP_S2L, OP_D31, 1'b0, 1'b0, D_NONE);
            5'd18:   u = mk(OP_S2H, OP_D31, 1'b1, 1'b0, D_NONE);
            5'd19:   u = mk(OP_S3L, OP_D12, 1'b0, 1'b0, D_NONE);
            5'd20:   u = mk(OP_S3H, OP_D12, 1'b1, 1'b0, D_NX);
            5'd21:   u = mk(OP_S1L, OP_E32, 1'b0, 1'b1, D_NONE);
            5'd22:   u = mk(OP_S1H, OP_E32, 1'b1, 1'b0, D_NONE);
            5'd23:   u = mk(OP_S2L, OP_E13, 1'b0, 1'b0, D_NONE);
            5'd24:   u = mk(OP_S2H, OP_E13, 1'b1, 1'b0, D_NONE);
            5'd25:   u = mk(OP_S3L, OP_E21, 1'b0, 1'b0, D_NONE);
            5'd26:   u = mk(OP_S3H, OP_E21, 1'b1, 1'b0, D_NY);
            default: u = mk(OP_PA,  OP_PA,  1'b0, 1'b1, D_NONE);
        endcase
        return u;
    endfunction

endpackage

@@ rtl/core/cone_circumcenter_estimator.sv @@
// Top level of the cone circumcenter estimator.
// Depends on cce_pkg, cce_ctrl and cce_datapath.
//
// Usage: points of one cluster arrive on the slave stream, one transaction per
// point, with tlast on the final point. Each point, while the point store has
// room, is written to it and summed. After the last point the block rounds the
// centroid with three serial divisions (an empty cluster goes straight to the
// result), then scans the store once, taking each point's plane distance and
// doing the three-slot insertion. The circumcenter program then runs on the
// shared multiplier, followed by two more divisions unless the determinant is
// zero. The result leaves as one master transaction and is held until it is
// taken; no point is accepted from the last point until the result transaction
// completes. Reset clears the cluster state and loads the default plane normal
// (0, 0, 1.0). The user must write plane registers only between clusters; the
// block itself does not enforce it.
module cone_circumcenter_estimator
    import cce_pkg::*;
#(
    parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,  // point_x, point_y, point_z, zero pad
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,  // center_x, center_y, center_z, zero pad
    output logic [1:0]           m_axis_tuser,  // status
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PLANE_W-1:0]   i_cfg_data
);
    t_cmd                      cmd;
    t_sts                      sts;
    logic signed [COORD_W-1:0] cx, cy, cz;
    t_status                   st;

    cce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cce_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_point   (s_axis_tdata[PT_W-1:0]),
        .o_cx      (cx),
        .o_cy      (cy),
        .o_cz      (cz),
        .o_status  (st)
    );

    assign m_axis_tdata = {4'b0000, cz, cy, cx};
    assign m_axis_tuser = st;
endmodule

@@ rtl/core/cce_ram.sv @@
// Generic single-port-write, registered-read RAM.
// Depends on nothing.
module cce_ram #(
    parameter int unsigned WIDTH = 60,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/cce_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on cce_pkg for the operand width.
module cce_div
    import cce_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);
    localparam int unsigned CW = $clog2(DIV_W);

    logic [DIV_W-1:0] r_rem, r_num, r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;
    logic [DIV_W:0]   trial, diff;
    logic             ge;

    always_comb begin
        trial = {r_rem, r_num[DIV_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            r_num <= {r_num[DIV_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule

@@ rtl/core/cce_datapath.sv @@
// Datapath: point store, sums, shared multiplier and accumulator, divider, kept points.
// Depends on cce_pkg, cce_ram and cce_div.
module cce_datapath
    import cce_pkg::*;
#(
    parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [PLANE_W-1:0]         i_cfg_data,
    input  logic [PT_W-1:0]            i_point,
    output logic signed [COORD_W-1:0]  o_cx,
    output logic signed [COORD_W-1:0]  o_cy,
    output logic signed [COORD_W-1:0]  o_cz,
    output t_status                    o_status
);
    localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
    localparam int unsigned AW    = $clog2(MAX_POINTS);
    localparam int unsigned SUM_W = COORD_W + CNT_W;

    logic signed [PLANE_W-1:0] r_pa, r_pb, r_pc;
    logic [CNT_W-1:0]          r_count, r_k;
    logic signed [SUM_W-1:0]   r_sx, r_sy, r_sz;
    logic [PT_W-1:0]           r_bp [3];
    logic [DIST_W-1:0]         r_bd [3];
    logic signed [COORD_W-1:0] r_cx, r_cy, r_cz;
    logic signed [COORD_W-1:0] r_ox, r_oy, r_oz;
    t_status                   r_st;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc, n_acc, r_ref, r_det, r_nx, r_ny;
    logic [SQ_W-1:0]           r_s1, r_s2, r_s3;

    logic [PT_W-1:0]           rdata;
    logic signed [COORD_W-1:0] px, py, pz;
    logic signed [COORD_W-1:0] ix, iy, iz;
    logic signed [COORD_W-1:0] x1, y1, x2, y2, x3, y3;
    logic signed [MUL_W-1:0]   opv [NUM_OPND];
    logic signed [MUL_W-1:0]   opa, opb;
    logic signed [ACC_W-1:0]   prod_ext, dist_s;
    logic [DIST_W-1:0]         pdist;
    logic                      room, i0, i1, i2;
    t_uop                      u;

    logic signed [ACC_W-1:0]   num_s, den_s;
    logic [DIV_W-1:0]          num_m, den_m, div_n, div_d, quot;
    logic                      neg, div_done;
    logic signed [COORD_W-1:0] qsat;

    assign ix = i_point[COORD_W-1:0];
    assign iy = i_point[2*COORD_W-1:COORD_W];
    assign iz = i_point[PT_W-1:2*COORD_W];
    assign room = r_count < CNT_W'(MAX_POINTS);

    cce_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load && room),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_point),
        .i_re   (i_cmd.rd),
        .i_raddr(r_k[AW-1:0]),
        .o_rdata(rdata)
    );

    assign px = rdata[COORD_W-1:0];
    assign py = rdata[2*COORD_W-1:COORD_W];
    assign pz = rdata[PT_W-1:2*COORD_W];
    assign x1 = r_bp[0][COORD_W-1:0];
    assign y1 = r_bp[0][2*COORD_W-1:COORD_W];
    assign x2 = r_bp[1][COORD_W-1:0];
    assign y2 = r_bp[1][2*COORD_W-1:COORD_W];
    assign x3 = r_bp[2][COORD_W-1:0];
    assign y3 = r_bp[2][2*COORD_W-1:COORD_W];

    always_comb begin
        opv[OP_PA]  = MUL_W'(r_pa);
        opv[OP_PB]  = MUL_W'(r_pb);
        opv[OP_PC]  = MUL_W'(r_pc);
        opv[OP_CX]  = MUL_W'(r_cx);
        opv[OP_CY]  = MUL_W'(r_cy);
        opv[OP_CZ]  = MUL_W'(r_cz);
        opv[OP_PX]  = MUL_W'(px);
        opv[OP_PY]  = MUL_W'(py);
        opv[OP_PZ]  = MUL_W'(pz);
        opv[OP_X1]  = MUL_W'(x1);
        opv[OP_Y1]  = MUL_W'(y1);
        opv[OP_X2]  = MUL_W'(x2);
        opv[OP_Y2]  = MUL_W'(y2);
        opv[OP_X3]  = MUL_W'(x3);
        opv[OP_Y3]  = MUL_W'(y3);
        opv[OP_D23] = MUL_W'(y2) - MUL_W'(y3);
        opv[OP_D31] = MUL_W'(y3) - MUL_W'(y1);
        opv[OP_D12] = MUL_W'(y1) - MUL_W'(y2);
        opv[OP_E32] = MUL_W'(x3) - MUL_W'(x2);
        opv[OP_E13] = MUL_W'(x1) - MUL_W'(x3);
        opv[OP_E21] = MUL_W'(x2) - MUL_W'(x1);
        opv[OP_S1L] = {2'b00, r_s1[HALF_W-1:0]};
        opv[OP_S1H] = {2'b00, r_s1[SQ_W-1:HALF_W]};
        opv[OP_S2L] = {2'b00, r_s2[HALF_W-1:0]};
        opv[OP_S2H] = {2'b00, r_s2[SQ_W-1:HALF_W]};
        opv[OP_S3L] = {2'b00, r_s3[HALF_W-1:0]};
        opv[OP_S3H] = {2'b00, r_s3[SQ_W-1:HALF_W]};
    end

    always_comb begin
        u        = uop_rom(i_cmd.pc);
        opa      = opv[u.a];
        opb      = opv[u.b];
        prod_ext = ACC_W'(r_prod);
        if (u.sh) begin
            prod_ext = prod_ext <<< HALF_W;
        end
        n_acc  = (u.clr ? '0 : r_acc) + prod_ext;
        dist_s = r_acc - r_ref;
        pdist  = dist_s[ACC_W-1] ? DIST_W'(-dist_s) : DIST_W'(dist_s);
        i0     = pdist < r_bd[0];
        i1     = !i0 && (pdist < r_bd[1]);
        i2     = !i0 && !i1 && (pdist < r_bd[2]);
    end

    always_comb begin
        case (i_cmd.div_sel)
            DS_CX:   num_s = ACC_W'(r_sx);
            DS_CY:   num_s = ACC_W'(r_sy);
            DS_CZ:   num_s = ACC_W'(r_sz);
            DS_NX:   num_s = r_nx;
            DS_NY:   num_s = r_ny;
            default: num_s = '0;
        endcase
        if (i_cmd.div_sel == DS_NX || i_cmd.div_sel == DS_NY) begin
            den_s = r_det;
        end else begin
            den_s = ACC_W'({1'b0, r_count});
        end
        num_m = num_s[ACC_W-1] ? DIV_W'(-num_s) : DIV_W'(num_s);
        den_m = den_s[ACC_W-1] ? DIV_W'(-den_s) : DIV_W'(den_s);
        div_n = (num_m << 1) + den_m;
        div_d = den_m << 1;
        neg   = num_s[ACC_W-1] ^ den_s[ACC_W-1];
    end

    cce_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (div_n),
        .i_den  (div_d),
        .o_done (div_done),
        .o_quot (quot)
    );

    always_comb begin
        if (!neg) begin
            qsat = (|quot[DIV_W-1:HALF_W-1]) ? CENTER_MAX : COORD_W'(quot);
        end else if (quot > DIV_W'(524288)) begin
            qsat = CENTER_MIN;
        end else begin
            qsat = COORD_W'(21'd0 - quot[HALF_W:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa <= '0;
            r_pb <= '0;
            r_pc <= 16'sd16384;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PLANE_A: r_pa <= i_cfg_data;
                CFG_PLANE_B: r_pb <= i_cfg_data;
                CFG_PLANE_C: r_pc <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sz    <= '0;
            for (int i = 0; i < 3; i++) begin
                r_bp[i] <= '0;
                r_bd[i] <= '1;
            end
            r_k  <= '0;
            r_st <= STAT_OK;
        end else begin
            if (i_cmd.load && room) begin
                r_count <= r_count + 1'b1;
                r_sx    <= r_sx + SUM_W'(ix);
                r_sy    <= r_sy + SUM_W'(iy);
                r_sz    <= r_sz + SUM_W'(iz);
            end
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.ins) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.ins) begin
                if (i0) begin
                    r_bp[2] <= r_bp[1];
                    r_bd[2] <= r_bd[1];
                    r_bp[1] <= r_bp[0];
                    r_bd[1] <= r_bd[0];
                    r_bp[0] <= rdata;
                    r_bd[0] <= pdist;
                end else if (i1) begin
                    r_bp[2] <= r_bp[1];
                    r_bd[2] <= r_bd[1];
                    r_bp[1] <= rdata;
                    r_bd[1] <= pdist;
                end else if (i2) begin
                    r_bp[2] <= rdata;
                    r_bd[2] <= pdist;
                end
            end
            if (i_cmd.set_empty) begin
                r_st <= STAT_EMPTY;
            end else if (i_cmd.set_zdet) begin
                r_st <= STAT_ZDET;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= opa * opb;
        end
        if (i_cmd.acc) begin
            r_acc <= n_acc;
            case (u.dest)
                D_REF:   r_ref <= n_acc;
                D_S1:    r_s1  <= SQ_W'(n_acc);
                D_S2:    r_s2  <= SQ_W'(n_acc);
                D_S3:    r_s3  <= SQ_W'(n_acc);
                D_DET:   r_det <= n_acc <<< 1;
                D_NX:    r_nx  <= n_acc;
                D_NY:    r_ny  <= n_acc;
                default: ;
            endcase
        end
        if (i_cmd.div_wr) begin
            case (i_cmd.div_sel)
                DS_CX:   r_cx <= qsat;
                DS_CY:   r_cy <= qsat;
                DS_CZ: begin
                    r_cz <= qsat;
                    r_oz <= qsat;
                end
                DS_NX:   r_ox <= qsat;
                DS_NY:   r_oy <= qsat;
                default: ;
            endcase
        end
        if (i_cmd.set_empty) begin
            r_ox <= '0;
            r_oy <= '0;
            r_oz <= '0;
        end else if (i_cmd.set_zdet) begin
            r_ox <= '0;
            r_oy <= '0;
        end
    end

    assign o_sts.cnt_zero = r_count == '0;
    assign o_sts.k_done   = r_k == r_count;
    assign o_sts.div_done = div_done;
    assign o_sts.det_zero = r_det == '0;
    assign o_cx     = r_ox;
    assign o_cy     = r_oy;
    assign o_cz     = r_oz;
    assign o_status = r_st;
endmodule

@@ rtl/core/cce_ctrl.sv @@
// Controller state machine that sequences loading, divisions, the plane pass and the
// circumcenter program. Depends on cce_pkg.
module cce_ctrl
    import cce_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_DGO   = 8'b0000_0010,
        S_DWAIT = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_ACC   = 8'b0001_0000,
        S_RD    = 8'b0010_0000,
        S_INS   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    t_dsel           r_dsel, n_dsel;

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_dsel  = r_dsel;
        o_cmd   = '0;
        o_cmd.pc      = r_pc;
        o_cmd.div_sel = r_dsel;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        n_dsel  = DS_CX;
                        n_state = S_DGO;
                    end
                end
            end
            S_DGO: begin
                if (r_dsel == DS_CX && i_sts.cnt_zero) begin
                    o_cmd.set_empty = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DWAIT;
                end
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_wr = 1'b1;
                    case (r_dsel)
                        DS_CX: begin
                            n_dsel  = DS_CY;
                            n_state = S_DGO;
                        end
                        DS_CY: begin
                            n_dsel  = DS_CZ;
                            n_state = S_DGO;
                        end
                        DS_CZ: begin
                            n_pc    = PC_REF_START;
                            n_state = S_MUL;
                        end
                        DS_NX: begin
                            n_dsel  = DS_NY;
                            n_state = S_DGO;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_pc == PC_REF_END) begin
                    o_cmd.k_clr = 1'b1;
                    n_state = S_RD;
                end else if (r_pc == PC_DIST_END) begin
                    n_state = S_INS;
                end else if (r_pc == PC_CIRC_END) begin
                    if (i_sts.det_zero) begin
                        o_cmd.set_zdet = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_dsel  = DS_NX;
                        n_state = S_DGO;
                    end
                end else begin
                    n_pc    = r_pc + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_RD: begin
                if (i_sts.k_done) begin
                    n_pc = PC_CIRC_START;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_pc = PC_DIST_START;
                end
                n_state = S_MUL;
            end
            S_INS: begin
                o_cmd.ins = 1'b1;
                n_state = S_RD;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_pc    <= '0;
            r_dsel  <= DS_CX;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_dsel  <= n_dsel;
        end
    end
endmodule

@@ verif/tb_cone_circumcenter_estimator.sv @@
// Self-checking testbench for cone_circumcenter_estimator.
// Drives point clusters under several plane normals and checks each center against
// a local predictor; depends on cce_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_cone_circumcenter_estimator;
    import cce_pkg::*;

    localparam int STORE_DEPTH = 256;
    localparam longint DIST_ALL_ONES = 64'hFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [19:0] z;
        logic [19:0] y;
        logic [19:0] x;
        logic        last;
    } t_point_item;

    typedef struct packed {
        logic [19:0] cx;
        logic [19:0] cy;
        logic [19:0] cz;
        t_status     st;
    } t_center;

    typedef enum int {SPREAD_WIDE, SPREAD_LOCAL, SPREAD_LINE, SPREAD_DUP} t_spread;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [PLANE_W-1:0]   i_cfg_data;

    cone_circumcenter_estimator dut (.*);

    t_point_item pending_points[$];
    t_center     expected_centers[$];

    longint plane_nx, plane_ny, plane_nz;
    longint store_x[STORE_DEPTH], store_y[STORE_DEPTH], store_z[STORE_DEPTH];
    int     held_points = 0;
    longint sum_x = 0, sum_y = 0, sum_z = 0;

    int  errors = 0;
    int  centers_seen = 0;
    int  points_sent = 0;
    int  cycle_count = 0;
    bit  quiet;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint div_nearest(longint num, longint den);
        longint unsigned n, d, q;
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (2 * n + d) / (2 * d);
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp20(longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    // Adds one accepted point; on the last point of a cluster queues the expected center.
    function automatic void absorb_point(logic [63:0] data, logic last);
        longint cx, cy, cz, ref_d, pdist, x1, y1, x2, y2, x3, y3, det, s1, s2, s3, nx, ny;
        longint kept_x[3], kept_y[3];
        longint unsigned kept_d[3], du;
        t_center c;
        if (held_points < STORE_DEPTH) begin
            store_x[held_points] = longint'($signed(data[19:0]));
            store_y[held_points] = longint'($signed(data[39:20]));
            store_z[held_points] = longint'($signed(data[59:40]));
            sum_x += store_x[held_points];
            sum_y += store_y[held_points];
            sum_z += store_z[held_points];
            held_points++;
        end
        if (!last) return;
        for (int i = 0; i < 3; i++) begin
            kept_x[i] = 0;
            kept_y[i] = 0;
            kept_d[i] = DIST_ALL_ONES;
        end
        c = '0;
        if (held_points == 0) begin
            c.st = STAT_EMPTY;
        end else begin
            cx = div_nearest(sum_x, longint'(held_points));
            cy = div_nearest(sum_y, longint'(held_points));
            cz = div_nearest(sum_z, longint'(held_points));
            ref_d = plane_nx * cx + plane_ny * cy + plane_nz * cz;
            for (int k = 0; k < held_points; k++) begin
                pdist = plane_nx * store_x[k] + plane_ny * store_y[k] + plane_nz * store_z[k]
                        - ref_d;
                du = (pdist < 0) ? -pdist : pdist;
                for (int i = 0; i < 3; i++) begin
                    if (du < kept_d[i]) begin
                        for (int j = 2; j > i; j--) begin
                            kept_x[j] = kept_x[j-1];
                            kept_y[j] = kept_y[j-1];
                            kept_d[j] = kept_d[j-1];
                        end
                        kept_x[i] = store_x[k];
                        kept_y[i] = store_y[k];
                        kept_d[i] = du;
                        break;
                    end
                end
            end
            x1 = kept_x[0]; y1 = kept_y[0];
            x2 = kept_x[1]; y2 = kept_y[1];
            x3 = kept_x[2]; y3 = kept_y[2];
            det = 2 * (x1 * (y2 - y3) + x2 * (y3 - y1) + x3 * (y1 - y2));
            c.cz = 20'(clamp20(cz));
            if (det == 0) begin
                c.st = STAT_ZDET;
            end else begin
                s1 = x1 * x1 + y1 * y1;
                s2 = x2 * x2 + y2 * y2;
                s3 = x3 * x3 + y3 * y3;
                nx = s1 * (y2 - y3) + s2 * (y3 - y1) + s3 * (y1 - y2);
                ny = s1 * (x3 - x2) + s2 * (x1 - x3) + s3 * (x2 - x1);
                c.cx = 20'(clamp20(div_nearest(nx, det)));
                c.cy = 20'(clamp20(div_nearest(ny, det)));
                c.st = STAT_OK;
            end
        end
        expected_centers.push_back(c);
        held_points = 0;
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
    endfunction

    // Sender: offers queued points, with random gaps except in the quiet part.
    int send_gap;
    always @(posedge i_clk) begin
        t_point_item p;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_point(s_axis_tdata, s_axis_tlast);
                points_sent++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 6) == 0) begin
                    send_gap = $urandom_range(0, 7);
                    s_axis_tvalid <= 1'b0;
                end else if (pending_points.size() > 0) begin
                    p = pending_points.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0, p.z, p.y, p.x};
                    s_axis_tlast  <= p.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each center transaction and stalls at random,
    // once for a long stretch so that the input side backs up.
    int  rx_stall;
    bit  long_hold_done;
    always @(posedge i_clk) begin
        t_center e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
            long_hold_done = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                centers_seen++;
                if (expected_centers.size() == 0) begin
                    $error("unexpected center transaction: x=%h y=%h z=%h status=%0d",
                           m_axis_tdata[19:0], m_axis_tdata[39:20], m_axis_tdata[59:40],
                           m_axis_tuser);
                    errors++;
                end else begin
                    e = expected_centers.pop_front();
                    if (m_axis_tdata[19:0] !== e.cx) begin
                        $error("center_x expected %h got %h", e.cx, m_axis_tdata[19:0]);
                        errors++;
                    end
                    if (m_axis_tdata[39:20] !== e.cy) begin
                        $error("center_y expected %h got %h", e.cy, m_axis_tdata[39:20]);
                        errors++;
                    end
                    if (m_axis_tdata[59:40] !== e.cz) begin
                        $error("center_z expected %h got %h", e.cz, m_axis_tdata[59:40]);
                        errors++;
                    end
                    if (m_axis_tuser !== e.st) begin
                        $error("status expected %0d got %0d", e.st, m_axis_tuser);
                        errors++;
                    end
                end
            end
            if (!long_hold_done && centers_seen >= 8 && m_axis_tvalid) begin
                long_hold_done = 1'b1;
                rx_stall = 600;
                m_axis_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                rx_stall = $urandom_range(0, 7);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** cone_circumcenter_estimator: FAILED **");
            $finish;
        end
    end

    function automatic logic [19:0] coord_near(longint base, int spread);
        return 20'(clamp20(base + $signed($urandom_range(0, 2 * spread)) - spread));
    endfunction

    task automatic queue_point(logic [19:0] x, logic [19:0] y, logic [19:0] z, logic last);
        t_point_item p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.last = last;
        pending_points.push_back(p);
    endtask

    task automatic queue_cluster(int n, t_spread kind);
        longint bx, by, bz;
        logic [19:0] x, y, z, dx, dy, dz;
        int radius;
        bx = $signed($urandom_range(0, 524287)) - 262144;
        by = $signed($urandom_range(0, 524287)) - 262144;
        bz = $signed($urandom_range(0, 524287)) - 262144;
        radius = 1 << $urandom_range(2, 14);
        dx = 20'($urandom);
        dy = 20'($urandom);
        dz = 20'($urandom);
        for (int i = 0; i < n; i++) begin
            case (kind)
                SPREAD_WIDE: begin
                    x = 20'($urandom);
                    y = 20'($urandom);
                    z = 20'($urandom);
                end
                SPREAD_LOCAL: begin
                    x = coord_near(bx, radius);
                    y = coord_near(by, radius);
                    z = coord_near(bz, radius);
                end
                SPREAD_LINE: begin
                    x = 20'(bx);
                    y = coord_near(by, radius);
                    z = coord_near(bz, radius);
                end
                default: begin
                    x = ($urandom_range(0, 1) == 0) ? dx : 20'(bx);
                    y = dy;
                    z = ($urandom_range(0, 1) == 0) ? dz : 20'(bz);
                end
            endcase
            queue_point(x, y, z, i == n - 1);
        end
    endtask

    task automatic write_plane(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_PLANE_A: plane_nx = longint'($signed(value));
            CFG_PLANE_B: plane_ny = longint'($signed(value));
            default:     plane_nz = longint'($signed(value));
        endcase
    endtask

    task automatic set_normal(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        write_plane(CFG_PLANE_A, a);
        write_plane(CFG_PLANE_B, b);
        write_plane(CFG_PLANE_C, c);
    endtask

    task automatic drain_clusters();
        wait (pending_points.size() == 0 && expected_centers.size() == 0 && !s_axis_tvalid);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic queue_random_clusters(int point_budget);
        int used, n;
        used = 0;
        while (used < point_budget) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 12);
            queue_cluster(n, t_spread'($urandom_range(0, 3)));
            used += n;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        plane_nx = 0;
        plane_ny = 0;
        plane_nz = 16384;
        quiet = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed clusters under the reset normal.
        queue_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 1'b1);
        queue_point(20'h80000, 20'h80000, 20'h80000, 1'b0);
        queue_point(20'h7FFFF, 20'h00000, 20'h80000, 1'b1);
        queue_point(20'h80000, 20'h7FFFF, 20'h00000, 1'b0);
        queue_point(20'h7FFFF, 20'h80000, 20'h00001, 1'b0);
        queue_point(20'h00001, 20'h00001, 20'hFFFFF, 1'b1);
        queue_point(20'h00400, 20'h00000, 20'h00000, 1'b0);
        queue_point(20'h00000, 20'h00400, 20'h00000, 1'b0);
        queue_point(20'hFFC00, 20'h00000, 20'h00000, 1'b1);
        queue_point(20'h00010, 20'h00010, 20'h00005, 1'b0);
        queue_point(20'h00020, 20'h00020, 20'h00005, 1'b0);
        queue_point(20'h00030, 20'h00030, 20'h00005, 1'b1);
        queue_point(20'h12345, 20'h54321, 20'h00000, 1'b0);
        queue_point(20'h12345, 20'h54321, 20'h00000, 1'b1);
        queue_point(20'h00000, 20'h00001, 20'h00000, 1'b0);
        queue_point(20'h00001, 20'h00000, 20'h00000, 1'b0);
        queue_point(20'h00001, 20'h00001, 20'h00000, 1'b0);
        queue_point(20'h00000, 20'h00000, 20'h7FFFF, 1'b1);
        drain_clusters();

        queue_random_clusters(120);
        drain_clusters();

        set_normal(16'sd16384, 16'sd0, 16'sd0);
        queue_random_clusters(150);
        queue_cluster(STORE_DEPTH + 3, SPREAD_WIDE);
        drain_clusters();

        set_normal(16'sd0, -16'sd16384, 16'sd0);
        queue_random_clusters(150);
        drain_clusters();

        set_normal(-16'sd16384, 16'sd16384, -16'sd16384);
        queue_random_clusters(150);
        queue_cluster(40, SPREAD_LOCAL);
        drain_clusters();

        set_normal(16'h7FFF, 16'h8000, 16'h0001);
        queue_random_clusters(120);
        drain_clusters();

        set_normal(16'($urandom), 16'($urandom), 16'($urandom));
        queue_random_clusters(100);
        drain_clusters();

        quiet = 1'b1;
        set_normal(16'sd0, 16'sd0, 16'sd16384);
        queue_random_clusters(80);
        drain_clusters();

        $display("Sent %0d points and checked %0d centers across seven plane normals,",
                 points_sent, centers_seen);
        $display("including short, collinear, duplicate and overfull clusters.");
        if (errors == 0) begin
            $display("** cone_circumcenter_estimator: PASSED **");
        end else begin
            $display("** cone_circumcenter_estimator: FAILED **");
        end
        $finish;
    end

endmodule
